// ----- hdl/fxf_pkg.sv -----
// Shared types and constants for the fixed-to-fp32 row writeout block.
package fxf_pkg;

	localparam int WordW = 32;
	localparam int DimW  = 15;
	localparam int BinW  = 31;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 31;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_FRAC_SHIFT = 3'd0,
		CFG_SLAB_LEN   = 3'd1,
		CFG_CORE_INDEX = 3'd2,
		CFG_ROWS_LOG2  = 3'd3,
		CFG_COLS_LOG2  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic seg_first;
		logic seg_last;
		logic slab_last;
	} flags_t;

	typedef struct packed {
		logic [WordW-1:0] word;
		logic [DimW-1:0]  row;
		logic [DimW-1:0]  col;
		flags_t           flags;
	} entry_t;

endpackage

// ----- hdl/fxf_front.sv -----
// Front end: slab walk tracking, row/column tagging and filtering of words.
module fxf_front #(
	parameter int MAX_DIM_LOG2 = 15
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [31:0]         word,
	input  logic                start,
	input  logic [30:0]         slab_len,
	input  logic [9:0]          core_index,
	input  logic [3:0]          rows_log2,
	input  logic [3:0]          cols_log2,
	output logic                emit,
	output fxf_pkg::entry_t     entry
);

	localparam logic [3:0] DimMin = 4'd9;
	localparam logic [3:0] DimMax = 4'(MAX_DIM_LOG2);

	logic [30:0] bins_seen_q;
	logic [14:0] row_q;
	logic [14:0] col_q;
	logic        active_q;

	logic [3:0]  rl, cl;
	logic [4:0]  dim_sum;
	logic [40:0] first;
	logic [40:0] first_hi;
	logic        pad;
	logic [41:0] remain;
	logic [30:0] nvalid;
	logic [15:0] last_col16;
	logic [14:0] last_col;
	logic [40:0] first_row;
	logic [30:0] seen_e;
	logic [14:0] row_e, col_e;
	logic        active_e;
	logic        at_row_end, is_last;

	always_comb begin
		rl = (rows_log2 < DimMin) ? DimMin : ((rows_log2 > DimMax) ? DimMax : rows_log2);
		cl = (cols_log2 < DimMin) ? DimMin : ((cols_log2 > DimMax) ? DimMax : cols_log2);
		dim_sum  = 5'(rl) + 5'(cl);
		first    = 41'(core_index) * 41'(slab_len);
		first_hi = first >> dim_sum;
		pad      = |first_hi;
		remain   = (42'd1 << dim_sum) - 42'(first);
		nvalid   = (remain > 42'(slab_len)) ? slab_len : remain[30:0];
		last_col16 = (16'd1 << cl) - 16'd1;
		last_col   = last_col16[14:0];
		first_row  = first >> cl;

		seen_e   = start ? '0 : bins_seen_q;
		row_e    = start ? first_row[14:0] : row_q;
		col_e    = start ? (first[14:0] & last_col) : col_q;
		active_e = start | active_q;

		at_row_end = col_e >= last_col;
		is_last    = (seen_e + 31'd1) == nvalid;
		emit       = !pad && active_e && (seen_e < nvalid);

		entry.word            = word;
		entry.row             = row_e;
		entry.col             = col_e;
		entry.flags.seg_first = (seen_e == '0) || (col_e == '0);
		entry.flags.seg_last  = at_row_end || is_last;
		entry.flags.slab_last = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_seen_q <= '0;
			row_q       <= '0;
			col_q       <= '0;
			active_q    <= 1'b0;
		end else if (take && !pad) begin
			if (emit) begin
				bins_seen_q <= seen_e + 31'd1;
				active_q    <= 1'b1;
				if (at_row_end) begin
					col_q <= '0;
					row_q <= row_e + 15'd1;
				end else begin
					col_q <= col_e + 15'd1;
					row_q <= row_e;
				end
			end else begin
				// idle walk stays idle; an exhausted walk stops here
				bins_seen_q <= seen_e;
				row_q       <= row_e;
				col_q       <= col_e;
				active_q    <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/fxf_queue.sv -----
// Four-entry queue between the walk front end and the conversion back end.
module fxf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fxf_pkg::entry_t push_data,
	input  logic            pop,
	output fxf_pkg::entry_t pop_data,
	output logic            not_empty,
	output logic            full,
	output logic [2:0]      count
);

	fxf_pkg::entry_t mem [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign not_empty = cnt_q != 3'd0;
	assign full      = cnt_q == 3'd4;
	assign count     = cnt_q;
	assign pop_data  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop)  rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

endmodule

// ----- hdl/fxf_conv.sv -----
// Back end: two-stage unsigned integer to fp32 conversion with output register.
module fxf_conv (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_v,
	input  fxf_pkg::entry_t in_e,
	output logic            in_take,
	input  logic [4:0]      frac_shift,
	input  logic            out_stall,
	output logic            out_v,
	output logic [31:0]     fp32,
	output fxf_pkg::entry_t out_e
);

	logic            v_s1, v_s2;
	fxf_pkg::entry_t e_s1;
	logic [31:0]     norm_s1;
	logic [4:0]      lz_s1;
	logic            zero_s1;
	logic            adv2, adv1;

	logic [31:0] n;
	logic [4:0]  lz;
	logic        guard, sticky, rup;
	logic [24:0] m25;
	logic [7:0]  e8;
	logic [22:0] frac;
	logic [7:0]  pexp;

	assign adv2    = !v_s2 || !out_stall;
	assign adv1    = !v_s1 || adv2;
	assign in_take = in_v && adv1;
	assign out_v   = v_s2;

	// leading-zero normalize in five shift steps
	always_comb begin
		n  = in_e.word;
		lz = '0;
		if (n[31:16] == '0) begin n = n << 16; lz[4] = 1'b1; end
		if (n[31:24] == '0) begin n = n << 8;  lz[3] = 1'b1; end
		if (n[31:28] == '0) begin n = n << 4;  lz[2] = 1'b1; end
		if (n[31:30] == '0) begin n = n << 2;  lz[1] = 1'b1; end
		if (n[31] == 1'b0)  begin n = n << 1;  lz[0] = 1'b1; end
	end

	always_comb begin
		guard  = norm_s1[7];
		sticky = |norm_s1[6:0];
		rup    = guard && (sticky || norm_s1[8]);
		m25    = {1'b0, norm_s1[31:8]} + 25'(rup);
		pexp   = 8'd31 - 8'(lz_s1) + 8'(m25[24]);
		e8     = pexp + 8'd127 - 8'(frac_shift);
		frac   = m25[24] ? 23'd0 : m25[22:0];
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			e_s1    <= in_e;
			norm_s1 <= n;
			lz_s1   <= lz;
			zero_s1 <= in_e.word == '0;
		end
		if (adv2) begin
			out_e <= e_s1;
			fp32  <= zero_s1 ? 32'd0 : {1'b0, e8, frac};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_take;
			if (adv2) v_s2 <= v_s1;
		end
	end

endmodule

// ----- hdl/fixed_to_fp32_row_writeout.sv -----
// A word that yields a result is registered in the queue, then stage 1, then stage 2,
// and shows on the outputs from stage 2; out_stall can hold it in any of these.
// Throughput: one word per cycle unless stalled; the front walk and conversion pipe
// each take a word per cycle, and a four-entry queue absorbs output stalls.
// Reset (arst_n low, asynchronous): walk state, queue and pipe valids clear;
// config registers return to scale 0, slab 0, core 0, rows/cols log2 of 9.
module fixed_to_fp32_row_writeout #(
	parameter int MAX_DIM_LOG2 = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_wdata,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] density_word,
	input  logic        slab_start,
	// result words
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] fp32_bits,
	output logic [14:0] dest_row,
	output logic [14:0] dest_col,
	output logic        segment_first,
	output logic        segment_last,
	output logic        slab_last
);

	logic [4:0]  frac_shift_q;
	logic [30:0] slab_len_q;
	logic [9:0]  core_index_q;
	logic [3:0]  rows_log2_q;
	logic [3:0]  cols_log2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_shift_q <= '0;
			slab_len_q   <= '0;
			core_index_q <= '0;
			rows_log2_q  <= 4'd9;
			cols_log2_q  <= 4'd9;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fxf_pkg::CFG_FRAC_SHIFT: frac_shift_q <= cfg_wdata[4:0];
				fxf_pkg::CFG_SLAB_LEN:   slab_len_q   <= cfg_wdata;
				fxf_pkg::CFG_CORE_INDEX: core_index_q <= cfg_wdata[9:0];
				fxf_pkg::CFG_ROWS_LOG2:  rows_log2_q  <= cfg_wdata[3:0];
				fxf_pkg::CFG_COLS_LOG2:  cols_log2_q  <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	logic            q_full, q_ne, take, emit, pop;
	logic [2:0]      q_count;
	fxf_pkg::entry_t f_entry, q_entry, o_entry;

	// front takes a word whenever the queue has room
	assign in_stall = q_full;
	assign take     = in_valid && !q_full;

	fxf_front #(.MAX_DIM_LOG2(MAX_DIM_LOG2)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.word       (density_word),
		.start      (slab_start),
		.slab_len   (slab_len_q),
		.core_index (core_index_q),
		.rows_log2  (rows_log2_q),
		.cols_log2  (cols_log2_q),
		.emit       (emit),
		.entry      (f_entry)
	);

	fxf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && emit),
		.push_data (f_entry),
		.pop       (pop),
		.pop_data  (q_entry),
		.not_empty (q_ne),
		.full      (q_full),
		.count     (q_count)
	);

	fxf_conv u_conv (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_v       (q_ne),
		.in_e       (q_entry),
		.in_take    (pop),
		.frac_shift (frac_shift_q),
		.out_stall  (out_stall),
		.out_v      (out_valid),
		.fp32       (fp32_bits),
		.out_e      (o_entry)
	);

	assign dest_row      = o_entry.row;
	assign dest_col      = o_entry.col;
	assign segment_first = o_entry.flags.seg_first;
	assign segment_last  = o_entry.flags.seg_last;
	assign slab_last     = o_entry.flags.slab_last;

`ifndef SYNTH
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= 3'd4) else $error("queue count overflow");
	a_last_ends_seg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && slab_last |-> segment_last) else $error("slab end without segment end");
	a_zero_exp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fp32_bits[30:23] == 8'd0 |-> fp32_bits == 32'd0)
		else $error("denormal result");
`endif

endmodule

// ----- bench/tb_fixed_to_fp32_row_writeout.sv -----
// Testbench for the fixed-point density to fp32 row writeout block.
module tb_fixed_to_fp32_row_writeout;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 12;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [30:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] density_word;
	logic        slab_start;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] fp32_bits;
	logic [14:0] dest_row;
	logic [14:0] dest_col;
	logic        segment_first;
	logic        segment_last;
	logic        slab_last;

	fixed_to_fp32_row_writeout uut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Shadow copy of the block's registers and walk position.
	logic [4:0]  sh_scale;
	logic [30:0] sh_slab;
	logic [9:0]  sh_core;
	logic [3:0]  sh_rows;
	logic [3:0]  sh_cols;
	logic [30:0] walk_bins;
	logic [14:0] walk_row;
	logic [14:0] walk_col;
	logic        walk_on;

	fxf_pkg::entry_t expected_q[$];
	int mismatches;
	int checked;
	int cycles;
	int words_sent;
	int snd_idle_pct;
	int rcv_idle_pct;

	// Unsigned integer to fp32, round to nearest even, exponent lowered by sc.
	function automatic logic [31:0] fixed_to_float(logic [31:0] u, logic [4:0] sc);
		int p;
		logic [32:0] m;
		logic [31:0] rem;
		logic [31:0] half;
		logic [7:0] e;
		if (u == 0)
			return 32'd0;
		p = 31;
		while (!u[p])
			p--;
		if (p <= 23) begin
			m = 33'(u) << (23 - p);
		end else begin
			rem = u & ((32'd1 << (p - 23)) - 1);
			half = 32'd1 << (p - 24);
			m = 33'(u >> (p - 23));
			if (rem > half || (rem == half && m[0]))
				m++;
			if (m == 33'h100_0000) begin
				m = m >> 1;
				p++;
			end
		end
		e = 8'(p + 127 - sc);
		return {1'b0, e, m[22:0]};
	endfunction

	function automatic int clamp_log2(logic [3:0] v);
		if (v < 9)
			return 9;
		if (v > 15)
			return 15;
		return v;
	endfunction

	// Advances the walk for one accepted word and queues its result, if any.
	task automatic predict_word(logic [31:0] w, logic st);
		int rl;
		int cl;
		logic [63:0] total;
		logic [63:0] first;
		logic [63:0] nvalid;
		logic [14:0] last_col;
		logic row_end;
		logic fin;
		fxf_pkg::entry_t r;
		rl = clamp_log2(sh_rows);
		cl = clamp_log2(sh_cols);
		total = 64'd1 << (rl + cl);
		last_col = 15'((32'd1 << cl) - 1);
		first = 64'(sh_core) * 64'(sh_slab);
		if (first >= total)
			return;
		nvalid = total - first;
		if (nvalid > 64'(sh_slab))
			nvalid = 64'(sh_slab);
		if (st) begin
			walk_bins = '0;
			walk_row = 15'(first >> cl);
			walk_col = 15'(first) & last_col;
			walk_on = 1'b1;
		end
		if (!walk_on)
			return;
		if (64'(walk_bins) >= nvalid) begin
			walk_on = 1'b0;
			return;
		end
		row_end = walk_col >= last_col;
		fin = 64'(walk_bins) + 1 == nvalid;
		r.word = fixed_to_float(w, sh_scale);
		r.row = walk_row;
		r.col = walk_col;
		r.flags.seg_first = walk_bins == 0 || walk_col == 0;
		r.flags.seg_last = row_end || fin;
		r.flags.slab_last = fin;
		expected_q.push_back(r);
		walk_bins = walk_bins + 1;
		if (row_end) begin
			walk_col = '0;
			walk_row = walk_row + 1;
		end else begin
			walk_col = walk_col + 1;
		end
	endtask

	// Sampling at the rising edge: accepted inputs feed the predictor,
	// accepted results are compared against the oldest expectation.
	always @(posedge clk) begin
		fxf_pkg::entry_t got;
		fxf_pkg::entry_t exp_r;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (cfg_we) begin
				case (fxf_pkg::cfg_idx_t'(cfg_index))
					fxf_pkg::CFG_FRAC_SHIFT: sh_scale = cfg_wdata[4:0];
					fxf_pkg::CFG_SLAB_LEN:   sh_slab = cfg_wdata;
					fxf_pkg::CFG_CORE_INDEX: sh_core = cfg_wdata[9:0];
					fxf_pkg::CFG_ROWS_LOG2:  sh_rows = cfg_wdata[3:0];
					fxf_pkg::CFG_COLS_LOG2:  sh_cols = cfg_wdata[3:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_word(density_word, slab_start);
			if (out_valid && !out_stall) begin
				got.word = fp32_bits;
				got.row = dest_row;
				got.col = dest_col;
				got.flags = {segment_first, segment_last, slab_last};
				checked++;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: %h row %0d col %0d",
							got.word, got.row, got.col);
				end else begin
					exp_r = expected_q.pop_front();
					if (got !== exp_r) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %h r%0d c%0d f%b, got %h r%0d c%0d f%b",
								exp_r.word, exp_r.row, exp_r.col, exp_r.flags,
								got.word, got.row, got.col, got.flags);
					end
				end
			end
		end
	end

	// Receiver stall, redrawn at each falling edge.
	always @(negedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		else
			out_stall <= 1'b0;
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_fixed_to_fp32_row_writeout: done, errors");
			$finish;
		end
	end

	task automatic write_reg(fxf_pkg::cfg_idx_t idx, logic [30:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drops valid, lets every pending result drain, then waits out the DrainCycles margin.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic set_grid(logic [4:0] sc, logic [30:0] slab, logic [9:0] core,
			logic [3:0] rl, logic [3:0] cl);
		settle();
		write_reg(fxf_pkg::CFG_FRAC_SHIFT, 31'(sc));
		write_reg(fxf_pkg::CFG_SLAB_LEN, slab);
		write_reg(fxf_pkg::CFG_CORE_INDEX, 31'(core));
		write_reg(fxf_pkg::CFG_ROWS_LOG2, 31'(rl));
		write_reg(fxf_pkg::CFG_COLS_LOG2, 31'(cl));
	endtask

	// One word: optional sender gap, then hold valid until accepted.
	// Valid stays high on return; the next word or settle() moves it.
	task automatic send_word(logic [31:0] w, logic st);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		density_word <= w;
		slab_start <= st;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom() >> $urandom_range(31);
			3: return (32'h0100_0000 | $urandom_range(255)) << $urandom_range(7);
			default: return $urandom();
		endcase
	endfunction

	// Directed rows: word, start flag and, where obvious, the expected fp32.
	typedef struct {
		logic [31:0] w;
		logic        st;
		logic        known;
		logic [31:0] fp;
	} dir_row_t;

	dir_row_t dir_tab[] = '{
		'{32'h0000_0005, 1'b0, 1'b0, 32'h0},          // walk not started: ignored
		'{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},  // zero gives +0
		'{32'h0000_0001, 1'b0, 1'b1, 32'h3F80_0000},  // 1.0
		'{32'hFFFF_FFFF, 1'b0, 1'b1, 32'h4F80_0000},  // rounds up to 2^32
		'{32'h8000_0000, 1'b0, 1'b1, 32'h4F00_0000},
		'{32'h0100_0001, 1'b0, 1'b1, 32'h4B80_0000},  // tie, rounds to even
		'{32'h0100_0003, 1'b0, 1'b1, 32'h4B80_0002},  // tie, rounds up
		'{32'h00FF_FFFF, 1'b0, 1'b1, 32'h4B7F_FFFF},  // exact 24 bits
		'{32'h0000_0002, 1'b0, 1'b1, 32'h4000_0000},
		'{32'h7FFF_FFC0, 1'b0, 1'b0, 32'h0},          // past slab end: no result
		'{32'h0000_0003, 1'b1, 1'b1, 32'h4040_0000}   // restart
	};

	initial begin
		logic [31:0] exp_fp;
		int nrand;
		int phase;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		density_word = '0;
		slab_start = 1'b0;
		sh_scale = '0;
		sh_slab = '0;
		sh_core = '0;
		sh_rows = 4'd9;
		sh_cols = 4'd9;
		walk_bins = '0;
		walk_row = '0;
		walk_col = '0;
		walk_on = 1'b0;
		mismatches = 0;
		checked = 0;
		cycles = 0;
		words_sent = 0;
		snd_idle_pct = 37;
		rcv_idle_pct = 64;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Reset registers: slab of zero bins, no word gives a result.
		send_word(32'h1234_5678, 1'b1);
		send_word(32'h1, 1'b0);

		// Eight-bin slab at bin 0, scale 0: directed table.
		set_grid(5'd0, 31'd8, 10'd0, 4'd9, 4'd9);
		foreach (dir_tab[i]) begin
			send_word(dir_tab[i].w, dir_tab[i].st);
			if (dir_tab[i].known) begin
				exp_fp = dir_tab[i].fp;
				// the queued expectation must match the value typed in the table
				if (expected_q.size() != 0 && expected_q[$].word !== exp_fp) begin
					mismatches++;
					if (mismatches <= 10)
						$display("table row %0d: predictor %h, table %h",
							i, expected_q[$].word, exp_fp);
				end
			end
		end
		// Full scale, clamped dims, padding core, wide slab.
		set_grid(5'd31, 31'd16, 10'd1, 4'd0, 4'd15);
		send_word(32'hFFFF_FFFF, 1'b1);
		send_word(32'h0000_0001, 1'b0);
		set_grid(5'd4, 31'h4000_0000, 10'd1023, 4'd15, 4'd15);
		send_word(32'h5, 1'b1);
		set_grid(5'd8, 31'd40, 10'd6, 4'd9, 4'd15);
		for (int k = 0; k < 8; k++)
			send_word(rand_word(), k == 0);
		// Slab clipped at the grid end: 2^18 bins, core 780 * 336 leaves 64 bins.
		set_grid(5'd2, 31'd336, 10'd780, 4'd9, 4'd9);
		for (int k = 0; k < 66; k++)
			send_word(rand_word(), k == 0);
		// Last core's slab ends exactly at the grid end.
		set_grid(5'd2, 31'd256, 10'd1023, 4'd9, 4'd9);
		send_word(32'h7, 1'b1);

		// Random part in three idling phases, small slabs so ends are frequent.
		nrand = 0;
		for (phase = 0; phase < 3; phase++) begin
			snd_idle_pct = phase == 0 ? 37 : (phase == 1 ? 64 : 0);
			rcv_idle_pct = phase == 0 ? 64 : (phase == 1 ? 37 : 0);
			for (int s = 0; nrand < 500 * (phase + 1); s++) begin
				int len;
				logic [9:0] core;
				logic [30:0] slab;
				slab = 31'($urandom_range(1, 12) * 8);
				core = $urandom_range(9) == 0 ? 10'($urandom()) : 10'($urandom_range(40));
				if ($urandom_range(19) == 0)
					slab = 31'($urandom()) & 31'h7FFF_FFF8;
				set_grid(5'($urandom()), slab, core,
					4'($urandom()), 4'($urandom_range(9, 15)));
				if (s == 3)
					settle();  // sender holds until everything has come out
				len = $urandom_range(5, 30);
				for (int k = 0; k < len; k++) begin
					// mostly one clean walk, some restarts and overrun
					send_word(rand_word(), k == 0 || $urandom_range(39) == 0);
					nrand++;
				end
			end
		end

		settle();
		$display("covered %0d words, %0d results checked, %0d mismatches",
			words_sent, checked, mismatches);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("tb_fixed_to_fp32_row_writeout: done, clean");
		end else begin
			$display("tb_fixed_to_fp32_row_writeout: done, errors");
		end
		$finish;
	end
endmodule
